// ----- hw/rtl/rrts_pkg.sv -----
package rrts_pkg;

   localparam int THREAD_W = 4;
   localparam int QUEUE_W  = 3;
   localparam int KIND_W   = 3;

   // Event codes.
   localparam logic [KIND_W-1:0] KIND_MAKE_READY = 3'd0;
   localparam logic [KIND_W-1:0] KIND_YIELD      = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WAIT       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_RELEASE    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [THREAD_W-1:0] thread_id;
      logic [QUEUE_W-1:0]  queue_id;
   } req_type;

   typedef struct packed {
      logic [THREAD_W-1:0] running_thread;
      logic                running_valid;
      logic                switch_needed;
      logic [THREAD_W-1:0] previous_thread;
      logic [THREAD_W-1:0] released_thread;
      logic                released_valid;
   } rsp_type;

   // Write port of the shared next-link store.
   typedef struct packed {
      logic                en;
      logic [THREAD_W-1:0] addr;
      logic [THREAD_W-1:0] data;
   } link_wr_type;

endpackage

// ----- hw/rtl/rrts_link_mem.sv -----
module rrts_link_mem #(
   parameter int THREADS = 16
) (
   input  logic                                clock,
   input  rrts_pkg::link_wr_type               wr,
   input  logic [rrts_pkg::THREAD_W-1:0]       rd_addr,
   output logic [rrts_pkg::THREAD_W-1:0]       rd_data
);

   localparam int IDX_W = $clog2(THREADS);

   // One next-link per thread; entries are meaningful only once written.
   logic [rrts_pkg::THREAD_W-1:0] link_ff [THREADS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_ff[IDX_W'(wr.addr)] <= wr.data;
      end
   end

   assign rd_data = link_ff[IDX_W'(rd_addr)];

endmodule

// ----- hw/rtl/rrts_engine.sv -----
module rrts_engine #(
   parameter int THREADS = 16,
   parameter int QUEUES  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   input  rrts_pkg::req_type item,
   output logic              rsp_valid,
   output rrts_pkg::rsp_type rsp_data
);

   localparam int QIDX_W = (QUEUES > 1) ? $clog2(QUEUES) : 1;

   logic [rrts_pkg::THREAD_W-1:0] ready_head_ff, ready_head_in;
   logic [rrts_pkg::THREAD_W-1:0] ready_tail_ff, ready_tail_in;
   logic                          ready_empty_ff, ready_empty_in;
   logic [rrts_pkg::THREAD_W-1:0] wait_head_ff [QUEUES];
   logic [rrts_pkg::THREAD_W-1:0] wait_tail_ff [QUEUES];
   logic [QUEUES-1:0]             wait_empty_ff;
   logic [rrts_pkg::THREAD_W-1:0] wait_head_in, wait_tail_in;
   logic                          wait_empty_in;
   logic                          wait_we;
   logic [rrts_pkg::THREAD_W-1:0] cur_ff, cur_in;
   logic                          cur_valid_ff, cur_valid_in;
   logic                          rsp_valid_ff;
   rrts_pkg::rsp_type             rsp_ff, rsp_in;

   rrts_pkg::link_wr_type         link_wr;
   logic [rrts_pkg::THREAD_W-1:0] link_rd_addr;
   logic [rrts_pkg::THREAD_W-1:0] link_rd_data;
   logic [rrts_pkg::THREAD_W-1:0] link_next;
   logic                          link_fwd;

   logic                          q_ok;
   logic                          th_ok;
   logic [QIDX_W-1:0]             qi;
   logic [rrts_pkg::THREAD_W-1:0] cur_wait_head, cur_wait_tail;
   logic                          cur_wait_empty;
   logic [rrts_pkg::THREAD_W-1:0] rh, rt;
   logic                          re;
   logic [rrts_pkg::THREAD_W-1:0] rel;
   logic                          rel_valid;

   rrts_link_mem #(
      .THREADS (THREADS)
   ) u_link_mem (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data)
   );

   assign q_ok  = 32'(item.queue_id) < QUEUES;
   assign th_ok = 32'(item.thread_id) < THREADS;
   assign qi    = QIDX_W'(item.queue_id);

   assign cur_wait_head  = wait_head_ff[qi];
   assign cur_wait_tail  = wait_tail_ff[qi];
   assign cur_wait_empty = wait_empty_ff[qi];

   // A release follows the link of the queue head; every other kind the ready head.
   assign link_rd_addr = (item.kind == rrts_pkg::KIND_RELEASE) ? cur_wait_head : ready_head_ff;
   assign link_fwd     = (item.kind == rrts_pkg::KIND_YIELD) || (item.kind == rrts_pkg::KIND_WAIT);

   // Yield and wait append before they take from the ready list, so a link
   // written in this transaction must be seen by the read in the same one.
   assign link_next = (link_fwd && link_wr.en && (link_wr.addr == link_rd_addr)) ?
                      link_wr.data : link_rd_data;

   // The next-link store is written whenever a thread is appended to a list
   // that already holds at least one thread.
   always_comb begin
      link_wr.en   = 1'b0;
      link_wr.addr = ready_tail_ff;
      link_wr.data = cur_ff;
      unique case (item.kind)
         rrts_pkg::KIND_MAKE_READY: begin
            if (th_ok && cur_valid_ff && !ready_empty_ff) begin
               link_wr.en   = 1'b1;
               link_wr.data = item.thread_id;
            end
         end
         rrts_pkg::KIND_YIELD: begin
            if (cur_valid_ff && !ready_empty_ff) begin
               link_wr.en = 1'b1;
            end
         end
         rrts_pkg::KIND_WAIT: begin
            if (cur_valid_ff && q_ok && !cur_wait_empty) begin
               link_wr.en   = 1'b1;
               link_wr.addr = cur_wait_tail;
            end
         end
         rrts_pkg::KIND_RELEASE: begin
            if (q_ok && !cur_wait_empty && cur_valid_ff && !ready_empty_ff) begin
               link_wr.en   = 1'b1;
               link_wr.data = cur_wait_head;
            end
         end
         default: begin
         end
      endcase
      if (!item_valid) begin
         link_wr.en = 1'b0;
      end
   end

   always_comb begin
      ready_head_in  = ready_head_ff;
      ready_tail_in  = ready_tail_ff;
      ready_empty_in = ready_empty_ff;
      wait_head_in   = cur_wait_head;
      wait_tail_in   = cur_wait_tail;
      wait_empty_in  = cur_wait_empty;
      wait_we        = 1'b0;
      cur_in         = cur_ff;
      cur_valid_in   = cur_valid_ff;
      rel            = '0;
      rel_valid      = 1'b0;
      rh             = ready_head_ff;
      rt             = ready_tail_ff;
      re             = ready_empty_ff;

      unique case (item.kind)
         rrts_pkg::KIND_MAKE_READY: begin
            if (th_ok) begin
               if (!cur_valid_ff) begin
                  cur_in       = item.thread_id;
                  cur_valid_in = 1'b1;
               end else if (ready_empty_ff) begin
                  ready_head_in  = item.thread_id;
                  ready_tail_in  = item.thread_id;
                  ready_empty_in = 1'b0;
               end else begin
                  ready_tail_in = item.thread_id;
               end
            end
         end
         rrts_pkg::KIND_YIELD,
         rrts_pkg::KIND_WAIT: begin
            if (cur_valid_ff && (item.kind == rrts_pkg::KIND_YIELD || q_ok)) begin
               if (item.kind == rrts_pkg::KIND_YIELD) begin
                  // The running thread goes to the back of the ready list.
                  if (ready_empty_ff) begin
                     rh = cur_ff;
                     rt = cur_ff;
                     re = 1'b0;
                  end else begin
                     rt = cur_ff;
                  end
               end else begin
                  wait_we = 1'b1;
                  if (cur_wait_empty) begin
                     wait_head_in  = cur_ff;
                     wait_tail_in  = cur_ff;
                     wait_empty_in = 1'b0;
                  end else begin
                     wait_tail_in  = cur_ff;
                  end
               end
               // Dispatch the head of the ready list, or go idle.
               if (re) begin
                  cur_valid_in = 1'b0;
                  cur_in       = '0;
               end else begin
                  cur_in       = rh;
                  cur_valid_in = 1'b1;
                  if (rh == rt) begin
                     re = 1'b1;
                  end else begin
                     rh = link_next;
                  end
               end
               ready_head_in  = rh;
               ready_tail_in  = rt;
               ready_empty_in = re;
            end
         end
         rrts_pkg::KIND_RELEASE: begin
            if (q_ok && !cur_wait_empty) begin
               rel          = cur_wait_head;
               rel_valid    = 1'b1;
               wait_we      = 1'b1;
               if (cur_wait_head == cur_wait_tail) begin
                  wait_empty_in = 1'b1;
               end else begin
                  wait_head_in = link_next;
               end
               if (!cur_valid_ff) begin
                  cur_in       = cur_wait_head;
                  cur_valid_in = 1'b1;
               end else if (ready_empty_ff) begin
                  ready_head_in  = cur_wait_head;
                  ready_tail_in  = cur_wait_head;
                  ready_empty_in = 1'b0;
               end else begin
                  ready_tail_in = cur_wait_head;
               end
            end
         end
         rrts_pkg::KIND_CLEAR: begin
            if (q_ok) begin
               wait_we       = 1'b1;
               wait_empty_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_in.running_thread  = cur_in;
      rsp_in.running_valid   = cur_valid_in;
      rsp_in.switch_needed   = (cur_valid_in != cur_valid_ff) || (cur_in != cur_ff);
      rsp_in.previous_thread = cur_ff;
      rsp_in.released_thread = rel;
      rsp_in.released_valid  = rel_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_head_ff  <= '0;
         ready_tail_ff  <= '0;
         ready_empty_ff <= 1'b1;
         wait_empty_ff  <= '1;
         cur_ff         <= '0;
         cur_valid_ff   <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= item_valid;
         if (item_valid) begin
            ready_head_ff  <= ready_head_in;
            ready_tail_ff  <= ready_tail_in;
            ready_empty_ff <= ready_empty_in;
            cur_ff         <= cur_in;
            cur_valid_ff   <= cur_valid_in;
            if (wait_we) begin
               wait_empty_ff[qi] <= wait_empty_in;
            end
         end
      end
   end

   // Queue heads and tails carry no reset: an empty flag guards them.
   always_ff @(posedge clock) begin
      if (item_valid && wait_we) begin
         wait_head_ff[qi] <= wait_head_in;
         wait_tail_ff[qi] <= wait_tail_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/round_robin_thread_scheduler_core.sv -----
// Channel    Ports                       Handshake
// request    req_data                    taken when start is high and busy is low
// response   rsp_valid, rsp_data         one cycle per result, cannot be held off
//
// One transaction is accepted per cycle while busy is low; its result appears
// after the input register and the result register.
// Each event is resolved through one read and at most one write of
// the next-link store, beside the list heads, tails and empty flags.
// Reset is synchronous; busy is high while reset is asserted and until its register clears after reset is released.
// The receiver cannot stall, so busy never rises outside reset.
module round_robin_thread_scheduler_core #(
   parameter int THREADS = 16,
   parameter int QUEUES  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   output rrts_pkg::rsp_type rsp_data
);

   logic              busy_ff;
   logic              item_valid_ff;
   rrts_pkg::req_type item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         item_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         item_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         item_ff <= req_data;
      end
   end

   assign busy = busy_ff || reset;

   rrts_engine #(
      .THREADS (THREADS),
      .QUEUES  (QUEUES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid_ff),
      .item       (item_ff),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int THREAD_W    = rrts_pkg::THREAD_W;
   localparam int QUEUE_W     = rrts_pkg::QUEUE_W;
   localparam int KIND_W      = rrts_pkg::KIND_W;
   localparam int NUM_THREADS = 1 << THREAD_W;
   localparam int NUM_QUEUES  = 1 << QUEUE_W;
   localparam int KIND_TOP    = (1 << KIND_W) - 1;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   rrts_pkg::req_type req_data;
   logic              rsp_valid;
   rrts_pkg::rsp_type rsp_data;

   round_robin_thread_scheduler_core #(
      .THREADS(NUM_THREADS),
      .QUEUES (NUM_QUEUES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   // Scheduler state as the testbench sees it.
   logic [THREAD_W-1:0] link_next    [NUM_THREADS];
   bit                  link_written [NUM_THREADS];
   logic [THREAD_W-1:0] rdy_head, rdy_tail;
   bit                  rdy_empty;
   logic [THREAD_W-1:0] wq_head  [NUM_QUEUES];
   logic [THREAD_W-1:0] wq_tail  [NUM_QUEUES];
   bit                  wq_empty [NUM_QUEUES];
   logic [THREAD_W-1:0] run_thread;
   bit                  run_valid;

   rrts_pkg::rsp_type expected_rsp_q[$];
   bit      gaps_on;
   int      mismatch_count;
   int      events_sent;
   int      results_checked;
   int      idle_entries;
   int      releases_found;

   task automatic reset_scheduler_state();
      for (int i = 0; i < NUM_THREADS; i++) begin
         link_next[i]    = '0;
         link_written[i] = 1'b0;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
         wq_head[i]  = '0;
         wq_tail[i]  = '0;
         wq_empty[i] = 1'b1;
      end
      rdy_head   = '0;
      rdy_tail   = '0;
      rdy_empty  = 1'b1;
      run_thread = '0;
      run_valid  = 1'b1;
   endtask

   function automatic void list_push(inout logic [THREAD_W-1:0] head,
                                     inout logic [THREAD_W-1:0] tail,
                                     inout bit empty,
                                     input logic [THREAD_W-1:0] th);
      if (empty) begin
         head  = th;
         tail  = th;
         empty = 1'b0;
      end else begin
         link_next[tail]    = th;
         link_written[tail] = 1'b1;
         tail               = th;
      end
   endfunction

   function automatic void list_pop(inout logic [THREAD_W-1:0] head,
                                    inout logic [THREAD_W-1:0] tail,
                                    inout bit empty,
                                    output logic [THREAD_W-1:0] th);
      th = head;
      if (head == tail)
         empty = 1'b1;
      else
         head = link_next[head];
   endfunction

   function automatic void hand_over(input logic [THREAD_W-1:0] th);
      if (!run_valid) begin
         run_thread = th;
         run_valid  = 1'b1;
      end else begin
         list_push(rdy_head, rdy_tail, rdy_empty, th);
      end
   endfunction

   function automatic void pick_next();
      if (rdy_empty) begin
         run_valid  = 1'b0;
         run_thread = '0;
      end else begin
         list_pop(rdy_head, rdy_tail, rdy_empty, run_thread);
         run_valid = 1'b1;
      end
   endfunction

   // True when the event would follow a link that was never written; such
   // events lie outside the block's contract and are sent as a make-ready instead.
   function automatic bit reads_unset_link(input rrts_pkg::req_type ev);
      logic [QUEUE_W-1:0] q;
      q = ev.queue_id;
      case (ev.kind)
         rrts_pkg::KIND_YIELD:
            return run_valid && !rdy_empty && rdy_head != run_thread &&
                   rdy_head != rdy_tail && !link_written[rdy_head];
         rrts_pkg::KIND_WAIT:
            return run_valid && !rdy_empty && rdy_head != rdy_tail &&
                   !link_written[rdy_head] && !(!wq_empty[q] && wq_tail[q] == rdy_head);
         rrts_pkg::KIND_RELEASE:
            return !wq_empty[q] && wq_head[q] != wq_tail[q] && !link_written[wq_head[q]];
         default:
            return 1'b0;
      endcase
   endfunction

   // Applies one accepted event to the scheduler state and queues its result.
   task automatic apply_event(input rrts_pkg::req_type ev);
      rrts_pkg::rsp_type   want;
      logic [THREAD_W-1:0] prev_thread;
      logic [THREAD_W-1:0] taken;
      bit                  prev_valid;
      prev_valid  = run_valid;
      prev_thread = run_valid ? run_thread : '0;
      want        = '0;
      case (ev.kind)
         rrts_pkg::KIND_MAKE_READY: hand_over(ev.thread_id);
         rrts_pkg::KIND_YIELD: begin
            if (run_valid) begin
               list_push(rdy_head, rdy_tail, rdy_empty, run_thread);
               pick_next();
            end
         end
         rrts_pkg::KIND_WAIT: begin
            if (run_valid) begin
               list_push(wq_head[ev.queue_id], wq_tail[ev.queue_id],
                         wq_empty[ev.queue_id], run_thread);
               pick_next();
            end
         end
         rrts_pkg::KIND_RELEASE: begin
            if (!wq_empty[ev.queue_id]) begin
               list_pop(wq_head[ev.queue_id], wq_tail[ev.queue_id],
                        wq_empty[ev.queue_id], taken);
               want.released_thread = taken;
               want.released_valid  = 1'b1;
               releases_found++;
               hand_over(taken);
            end
         end
         rrts_pkg::KIND_CLEAR: wq_empty[ev.queue_id] = 1'b1;
         default: ;
      endcase
      want.running_thread  = run_valid ? run_thread : '0;
      want.running_valid   = run_valid;
      want.switch_needed   = (run_valid != prev_valid) || (want.running_thread != prev_thread);
      want.previous_thread = prev_thread;
      if (prev_valid && !run_valid)
         idle_entries++;
      expected_rsp_q.push_back(want);
   endtask

   function automatic rrts_pkg::req_type make_event(input int kind, input int th, input int q);
      rrts_pkg::req_type ev;
      ev.kind      = kind[KIND_W-1:0];
      ev.thread_id = th[THREAD_W-1:0];
      ev.queue_id  = q[QUEUE_W-1:0];
      return ev;
   endfunction

   task automatic send_event(input rrts_pkg::req_type ev);
      rrts_pkg::req_type item;
      int                gap;
      item = ev;
      if (reads_unset_link(item))
         item.kind = rrts_pkg::KIND_MAKE_READY;
      gap = gaps_on ? int'($urandom_range(0, 10)) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_event(item);
      events_sent++;
   endtask

   function automatic rrts_pkg::req_type random_event();
      rrts_pkg::req_type ev;
      int                pick;
      int                base;
      ev.thread_id = THREAD_W'($urandom_range(0, NUM_THREADS - 1));
      ev.queue_id  = QUEUE_W'($urandom_range(0, NUM_QUEUES - 1));
      pick         = int'($urandom_range(0, 99));
      if (pick < 25) begin
         ev.kind = rrts_pkg::KIND_MAKE_READY;
      end else if (pick < 45) begin
         ev.kind = rrts_pkg::KIND_YIELD;
      end else if (pick < 65) begin
         ev.kind = rrts_pkg::KIND_WAIT;
      end else if (pick < 90) begin
         ev.kind = rrts_pkg::KIND_RELEASE;
         // Most releases are aimed at a queue that actually holds waiters.
         if ($urandom_range(0, 4) != 0) begin
            base = int'(ev.queue_id);
            for (int k = NUM_QUEUES - 1; k >= 0; k--)
               if (!wq_empty[(base + k) % NUM_QUEUES])
                  ev.queue_id = QUEUE_W'((base + k) % NUM_QUEUES);
         end
      end else if (pick < 95) begin
         ev.kind = rrts_pkg::KIND_CLEAR;
      end else begin
         ev.kind = KIND_W'($urandom_range(int'(rrts_pkg::KIND_CLEAR) + 1, KIND_TOP));
      end
      return ev;
   endfunction

   task automatic check_field(input string name, input logic [THREAD_W-1:0] want,
                              input logic [THREAD_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_results
      rrts_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("running_thread", want.running_thread, rsp_data.running_thread);
            check_field("running_valid", THREAD_W'(want.running_valid),
                        THREAD_W'(rsp_data.running_valid));
            check_field("switch_needed", THREAD_W'(want.switch_needed),
                        THREAD_W'(rsp_data.switch_needed));
            check_field("previous_thread", want.previous_thread, rsp_data.previous_thread);
            check_field("released_thread", want.released_thread, rsp_data.released_thread);
            check_field("released_valid", THREAD_W'(want.released_valid),
                        THREAD_W'(rsp_data.released_valid));
            results_checked++;
         end
      end
   end

   // Walks through every event kind and the corner cases of the lists.
   task automatic test_directed_cases();
      gaps_on = 1'b1;
      send_event(make_event(rrts_pkg::KIND_YIELD, 0, 0));       // nothing ready: main thread kept
      send_event(make_event(rrts_pkg::KIND_MAKE_READY, 15, 7));
      send_event(make_event(rrts_pkg::KIND_MAKE_READY, 5, 0));
      send_event(make_event(rrts_pkg::KIND_YIELD, 0, 7));
      send_event(make_event(rrts_pkg::KIND_WAIT, 15, 7));
      send_event(make_event(rrts_pkg::KIND_WAIT, 0, 0));
      send_event(make_event(rrts_pkg::KIND_RELEASE, 0, 3));     // empty queue
      send_event(make_event(rrts_pkg::KIND_RELEASE, 15, 7));
      send_event(make_event(rrts_pkg::KIND_WAIT, 0, 7));
      send_event(make_event(rrts_pkg::KIND_WAIT, 15, 7));       // ready list empty: goes idle
      send_event(make_event(rrts_pkg::KIND_YIELD, 15, 7));      // idle: no effect
      send_event(make_event(rrts_pkg::KIND_WAIT, 0, 2));        // idle: no effect
      send_event(make_event(rrts_pkg::KIND_RELEASE, 0, 7));     // released thread runs at once
      send_event(make_event(rrts_pkg::KIND_MAKE_READY, 0, 0));  // running thread queued again
      send_event(make_event(rrts_pkg::KIND_YIELD, 0, 0));
      send_event(make_event(rrts_pkg::KIND_CLEAR, 15, 7));
      send_event(make_event(rrts_pkg::KIND_RELEASE, 0, 7));
      for (int k = rrts_pkg::KIND_CLEAR + 1; k <= KIND_TOP; k++)
         send_event(make_event(k, 15, 7));
      send_event(make_event(rrts_pkg::KIND_CLEAR, 0, 0));
      send_event(make_event(rrts_pkg::KIND_WAIT, 9, 4));
      send_event(make_event(rrts_pkg::KIND_WAIT, 9, 4));
      send_event(make_event(rrts_pkg::KIND_MAKE_READY, 9, 1));  // made ready while idle
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      repeat (200) send_event(random_event());
   endtask

   // Long lists on one queue: fill, drain through waits, then release them all; one round clears the queue first.
   task automatic test_queue_chains();
      int q;
      for (int round = 0; round < 4; round++) begin
         gaps_on = round[0];
         q       = $urandom_range(0, NUM_QUEUES - 1);
         for (int i = 1; i <= 8; i++)
            send_event(make_event(rrts_pkg::KIND_MAKE_READY, (i * 3 + round) % NUM_THREADS,
                                  $urandom_range(0, NUM_QUEUES - 1)));
         repeat (10) send_event(make_event(rrts_pkg::KIND_WAIT,
                                           $urandom_range(0, NUM_THREADS - 1), q));
         if (round == 2)
            send_event(make_event(rrts_pkg::KIND_CLEAR, $urandom_range(0, NUM_THREADS - 1), q));
         repeat (10) send_event(make_event(rrts_pkg::KIND_RELEASE,
                                           $urandom_range(0, NUM_THREADS - 1), q));
         repeat (3) send_event(make_event(rrts_pkg::KIND_YIELD,
                                          $urandom_range(0, NUM_THREADS - 1), q));
      end
   endtask

   task automatic test_random_traffic();
      rrts_pkg::req_type ev;
      int                counted;
      counted = 0;
      while (counted < 1000) begin
         if (counted % 40 == 0)
            gaps_on = ($urandom_range(0, 3) != 0);
         ev = random_event();
         send_event(ev);
         if (ev.kind <= rrts_pkg::KIND_CLEAR)
            counted++;
      end
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      gaps_on        = 1'b0;
      mismatch_count = 0;
      events_sent    = 0;
      results_checked = 0;
      idle_entries   = 0;
      releases_found = 0;
      reset_scheduler_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_back_to_back();
      test_queue_chains();
      test_random_traffic();

      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      $display("Sent %0d scheduler events and checked %0d results.", events_sent,
               results_checked);
      $display("The scheduler went idle %0d times and %0d waiters were released.",
               idle_entries, releases_found);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout: %0d results still outstanding", expected_rsp_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
